>>> design/wwr_pkg.sv
// Shared types, constants and helpers of the watermark window reorder block.
`default_nettype none
package wwr_pkg;

	localparam int HEAP_DEPTH  = 64;
	localparam int MAX_RELEASE = 32;
	localparam int TIME_BITS   = 40;
	localparam int TAG_BITS    = 12;
	localparam int SEQ_BITS    = 12;
	localparam int CFG_BITS    = 31;
	localparam int IDX_BITS    = $clog2(HEAP_DEPTH);
	localparam int CNT_BITS    = IDX_BITS + 1;
	localparam int REL_BITS    = $clog2(MAX_RELEASE + 1);
	localparam int DROP_BITS   = 6;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [TAG_BITS-1:0]  tag_t;
	typedef logic [SEQ_BITS-1:0]  seq_t;
	typedef logic [IDX_BITS-1:0]  idx_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;

	typedef struct packed {
		time_t ts;
		seq_t  seq;
		tag_t  tag;
	} entry_t;

	typedef enum logic {
		CFG_WINDOW    = 1'b0,
		CFG_WATERMARK = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_HELD     = 2'd0,
		ST_RELEASED = 2'd1,
		ST_LATE     = 2'd2,
		ST_FULL     = 2'd3
	} status_code_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_PUSH_RD,
		S_PUSH_CMP,
		S_FLUSH_CHK,
		S_FLUSH_TOP,
		S_EMIT_REC,
		S_POP_LAST,
		S_POP_LOAD,
		S_POP_RD,
		S_POP_CMP,
		S_STATUS
	} state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD_IN,
		DP_START,
		DP_MARK_LATE,
		DP_MARK_FULL,
		DP_PUSH_INIT,
		DP_PUSH_ROOT,
		DP_PUSH_RD,
		DP_PUSH_CMP,
		DP_FLUSH_RD,
		DP_TOP,
		DP_EMIT_REC,
		DP_DROP_CNT,
		DP_POP_LAST,
		DP_POP_LOAD,
		DP_POP_RD
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   pop_cmp;
		logic   emit_stat;
	} dp_cmd_t;

	typedef struct packed {
		logic started;
		logic late;
		logic full;
		logic flush_go;
		logic i_zero;
		logic x_first;
		logic top_in_win;
		logic pop_done;
		logic rel_max;
		logic out_free;
	} dp_stat_t;

	// a leaves before b: earlier time, or same time and earlier arrival mod 4096
	function automatic logic comes_first(entry_t a, entry_t b);
		seq_t d;
		d = a.seq - b.seq;
		if (a.ts != b.ts)
			return a.ts < b.ts;
		return d[SEQ_BITS-1];
	endfunction

endpackage
`default_nettype wire

>>> design/wwr_in_if.sv
// Record input channel.
`default_nettype none
interface wwr_in_if;
	logic             valid;
	logic             ready;
	wwr_pkg::time_t   timestamp;
	wwr_pkg::tag_t    record_tag;
	modport source (output valid, output timestamp, output record_tag, input ready);
	modport sink (input valid, input timestamp, input record_tag, output ready);
endinterface
`default_nettype wire

>>> design/wwr_out_if.sv
// Result output channel.
`default_nettype none
interface wwr_out_if;
	logic           valid;
	logic           ready;
	logic           is_record;
	wwr_pkg::time_t out_timestamp;
	wwr_pkg::tag_t  out_tag;
	logic [1:0]     status;
	logic [5:0]     dropped_count;
	logic           last;
	modport source (output valid, output is_record, output out_timestamp, output out_tag,
		output status, output dropped_count, output last, input ready);
	modport sink (input valid, input is_record, input out_timestamp, input out_tag,
		input status, input dropped_count, input last, output ready);
endinterface
`default_nettype wire

>>> design/wwr_cfg_if.sv
// Configuration write channel.
`default_nettype none
interface wwr_cfg_if;
	logic                           valid;
	logic                           ready;
	logic                           index;
	logic [wwr_pkg::CFG_BITS-1:0]   data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> design/wwr_dpath.sv
// Datapath: heap memory, window registers, counters and output register.
`default_nettype none
module wwr_dpath (
	input  wire              clk,
	input  wire              arst_n,
	input  wwr_pkg::dp_cmd_t cmd,
	output wwr_pkg::dp_stat_t stat,
	wwr_in_if.sink           rec_in,
	wwr_out_if.source        rec_out,
	wwr_cfg_if.sink          cfg
);
	wwr_pkg::entry_t mem [wwr_pkg::HEAP_DEPTH];
	wwr_pkg::entry_t ra_q, rb_q, x_q, top_q, wdata, best;
	wwr_pkg::idx_t   ra_addr, rb_addr, waddr, i_q, parent;
	wwr_pkg::cnt_t   cnt_q, lchild, rchild, m_idx;
	logic            we;
	wwr_pkg::time_t  t_q, left_q;
	wwr_pkg::tag_t   tag_q;
	wwr_pkg::seq_t   seq_q;
	logic [wwr_pkg::TIME_BITS:0]   right_q;
	logic [wwr_pkg::TIME_BITS+1:0] thresh;
	logic [wwr_pkg::CFG_BITS-1:0]  win_q, wm_q;
	logic [wwr_pkg::REL_BITS-1:0]  rel_q;
	logic [wwr_pkg::DROP_BITS-1:0] drops_q;
	logic started_q, late_q, full_q, popped_q;
	logic out_valid_q, out_free, out_isrec_q, out_last_q;
	wwr_pkg::time_t out_ts_q;
	wwr_pkg::tag_t  out_tag_q;
	logic [1:0]     out_status_q;
	logic [5:0]     out_drops_q;
	wwr_pkg::status_code_t code;

	assign parent = i_q - wwr_pkg::idx_t'(1) >> 1;
	assign lchild = {i_q, 1'b1};
	assign rchild = lchild + wwr_pkg::cnt_t'(1);
	assign thresh = {1'b0, right_q} + {{(wwr_pkg::TIME_BITS+2-wwr_pkg::CFG_BITS){1'b0}}, wm_q};
	assign out_free = !out_valid_q || rec_out.ready;

	always_comb begin
		m_idx = {1'b0, i_q};
		best = x_q;
		if (lchild < cnt_q && wwr_pkg::comes_first(ra_q, best)) begin
			m_idx = lchild;
			best = ra_q;
		end
		if (rchild < cnt_q && wwr_pkg::comes_first(rb_q, best)) begin
			m_idx = rchild;
			best = rb_q;
		end
	end

	always_comb begin
		ra_addr = '0;
		rb_addr = rchild[wwr_pkg::IDX_BITS-1:0];
		we = 1'b0;
		waddr = i_q;
		wdata = x_q;
		case (cmd.op)
			wwr_pkg::DP_PUSH_RD:  ra_addr = parent;
			wwr_pkg::DP_POP_LAST: ra_addr = wwr_pkg::idx_t'(cnt_q - wwr_pkg::cnt_t'(1));
			wwr_pkg::DP_POP_RD:   ra_addr = lchild[wwr_pkg::IDX_BITS-1:0];
			wwr_pkg::DP_PUSH_ROOT: begin
				we = 1'b1;
				waddr = '0;
			end
			wwr_pkg::DP_PUSH_CMP: begin
				we = 1'b1;
				if (wwr_pkg::comes_first(x_q, ra_q))
					wdata = ra_q;
			end
			default: ;
		endcase
		if (cmd.pop_cmp) begin
			we = 1'b1;
			wdata = best;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		ra_q <= mem[ra_addr];
		rb_q <= mem[rb_addr];
	end

	always_comb begin
		if (late_q)
			code = wwr_pkg::ST_LATE;
		else if (full_q)
			code = wwr_pkg::ST_FULL;
		else if (popped_q)
			code = wwr_pkg::ST_RELEASED;
		else
			code = wwr_pkg::ST_HELD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			seq_q <= '0;
			left_q <= '0;
			right_q <= '0;
			started_q <= 1'b0;
			win_q <= wwr_pkg::CFG_BITS'(60);
			wm_q <= wwr_pkg::CFG_BITS'(10);
			out_valid_q <= 1'b0;
			late_q <= 1'b0;
			full_q <= 1'b0;
			popped_q <= 1'b0;
			rel_q <= '0;
			drops_q <= '0;
		end else begin
			if (cfg.valid) begin
				case (wwr_pkg::cfg_idx_t'(cfg.index))
					wwr_pkg::CFG_WINDOW:    win_q <= cfg.data;
					wwr_pkg::CFG_WATERMARK: wm_q <= cfg.data;
					default: ;
				endcase
			end
			if (cmd.emit_stat || cmd.op == wwr_pkg::DP_EMIT_REC)
				out_valid_q <= 1'b1;
			else if (rec_out.ready)
				out_valid_q <= 1'b0;
			case (cmd.op)
				wwr_pkg::DP_LOAD_IN: begin
					late_q <= 1'b0;
					full_q <= 1'b0;
					popped_q <= 1'b0;
					rel_q <= '0;
					drops_q <= '0;
				end
				wwr_pkg::DP_START: begin
					started_q <= 1'b1;
					left_q <= t_q;
					right_q <= {1'b0, t_q} + {{(wwr_pkg::TIME_BITS+1-wwr_pkg::CFG_BITS){1'b0}}, win_q};
					cnt_q <= cnt_q + wwr_pkg::cnt_t'(1);
					seq_q <= seq_q + wwr_pkg::seq_t'(1);
				end
				wwr_pkg::DP_PUSH_INIT: begin
					cnt_q <= cnt_q + wwr_pkg::cnt_t'(1);
					seq_q <= seq_q + wwr_pkg::seq_t'(1);
				end
				wwr_pkg::DP_MARK_LATE: late_q <= 1'b1;
				wwr_pkg::DP_MARK_FULL: full_q <= 1'b1;
				wwr_pkg::DP_TOP: begin
					if ({1'b0, ra_q.ts} > right_q) begin
						left_q <= ra_q.ts;
						right_q <= {1'b0, ra_q.ts} +
							{{(wwr_pkg::TIME_BITS+1-wwr_pkg::CFG_BITS){1'b0}}, win_q};
					end
				end
				wwr_pkg::DP_EMIT_REC: rel_q <= rel_q + wwr_pkg::REL_BITS'(1);
				wwr_pkg::DP_DROP_CNT: begin
					if (drops_q != '1)
						drops_q <= drops_q + wwr_pkg::DROP_BITS'(1);
				end
				wwr_pkg::DP_POP_LAST: begin
					cnt_q <= cnt_q - wwr_pkg::cnt_t'(1);
					popped_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			wwr_pkg::DP_LOAD_IN: begin
				t_q <= rec_in.timestamp;
				tag_q <= rec_in.record_tag;
			end
			wwr_pkg::DP_START, wwr_pkg::DP_PUSH_INIT: begin
				x_q <= '{ts: t_q, seq: seq_q, tag: tag_q};
				i_q <= cnt_q[wwr_pkg::IDX_BITS-1:0];
			end
			wwr_pkg::DP_PUSH_CMP: begin
				if (wwr_pkg::comes_first(x_q, ra_q))
					i_q <= parent;
			end
			wwr_pkg::DP_TOP: top_q <= ra_q;
			wwr_pkg::DP_POP_LOAD: begin
				x_q <= ra_q;
				i_q <= '0;
			end
			wwr_pkg::DP_EMIT_REC: begin
				out_isrec_q <= 1'b1;
				out_ts_q <= top_q.ts;
				out_tag_q <= top_q.tag;
				out_status_q <= '0;
				out_drops_q <= '0;
				out_last_q <= 1'b0;
			end
			default: ;
		endcase
		if (cmd.pop_cmp)
			i_q <= m_idx[wwr_pkg::IDX_BITS-1:0];
		if (cmd.emit_stat) begin
			out_isrec_q <= 1'b0;
			out_ts_q <= '0;
			out_tag_q <= '0;
			out_status_q <= code;
			out_drops_q <= drops_q;
			out_last_q <= 1'b1;
		end
	end

	assign stat.started    = started_q;
	assign stat.late       = t_q < left_q;
	assign stat.full       = cnt_q == wwr_pkg::cnt_t'(wwr_pkg::HEAP_DEPTH);
	assign stat.flush_go   = ({2'b00, t_q} >= thresh) && cnt_q != '0;
	assign stat.i_zero     = i_q == '0;
	assign stat.x_first    = wwr_pkg::comes_first(x_q, ra_q);
	assign stat.top_in_win = {1'b0, ra_q.ts} <= right_q;
	assign stat.pop_done   = m_idx == {1'b0, i_q};
	assign stat.rel_max    = rel_q == wwr_pkg::REL_BITS'(wwr_pkg::MAX_RELEASE);
	assign stat.out_free   = out_free;

	assign cfg.ready = 1'b1;
	assign rec_in.ready = 1'b0 | (cmd.op == wwr_pkg::DP_LOAD_IN);
	assign rec_out.valid = out_valid_q;
	assign rec_out.is_record = out_isrec_q;
	assign rec_out.out_timestamp = out_ts_q;
	assign rec_out.out_tag = out_tag_q;
	assign rec_out.status = out_status_q;
	assign rec_out.dropped_count = out_drops_q;
	assign rec_out.last = out_last_q;
endmodule
`default_nettype wire

>>> design/wwr_ctrl.sv
// Controller: sequences heap insert, window flush and pop sift.
`default_nettype none
module wwr_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wwr_pkg::dp_stat_t stat,
	output wwr_pkg::dp_cmd_t  cmd
);
	wwr_pkg::state_t state_q, state_d;
	logic first_q, first_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wwr_pkg::S_IDLE;
			first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			first_q <= first_d;
		end
	end

	always_comb begin
		state_d = state_q;
		first_d = first_q;
		case (state_q)
			wwr_pkg::S_IDLE: if (in_valid) state_d = wwr_pkg::S_CHECK;
			wwr_pkg::S_CHECK: begin
				first_d = !stat.started;
				if (!stat.started)
					state_d = wwr_pkg::S_PUSH_RD;
				else if (stat.late)
					state_d = wwr_pkg::S_STATUS;
				else if (stat.full)
					state_d = wwr_pkg::S_FLUSH_CHK;
				else
					state_d = wwr_pkg::S_PUSH_RD;
			end
			wwr_pkg::S_PUSH_RD: begin
				if (stat.i_zero)
					state_d = first_q ? wwr_pkg::S_STATUS : wwr_pkg::S_FLUSH_CHK;
				else
					state_d = wwr_pkg::S_PUSH_CMP;
			end
			wwr_pkg::S_PUSH_CMP: begin
				if (stat.x_first)
					state_d = wwr_pkg::S_PUSH_RD;
				else
					state_d = first_q ? wwr_pkg::S_STATUS : wwr_pkg::S_FLUSH_CHK;
			end
			wwr_pkg::S_FLUSH_CHK:
				state_d = stat.flush_go ? wwr_pkg::S_FLUSH_TOP : wwr_pkg::S_STATUS;
			wwr_pkg::S_FLUSH_TOP:
				state_d = stat.top_in_win ? wwr_pkg::S_EMIT_REC : wwr_pkg::S_STATUS;
			wwr_pkg::S_EMIT_REC: if (stat.rel_max || stat.out_free) state_d = wwr_pkg::S_POP_LAST;
			wwr_pkg::S_POP_LAST: state_d = wwr_pkg::S_POP_LOAD;
			wwr_pkg::S_POP_LOAD: state_d = wwr_pkg::S_POP_RD;
			wwr_pkg::S_POP_RD:   state_d = wwr_pkg::S_POP_CMP;
			wwr_pkg::S_POP_CMP:
				state_d = stat.pop_done ? wwr_pkg::S_FLUSH_CHK : wwr_pkg::S_POP_RD;
			wwr_pkg::S_STATUS: if (stat.out_free) state_d = wwr_pkg::S_IDLE;
			default: state_d = wwr_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = wwr_pkg::DP_NOP;
		cmd.pop_cmp = 1'b0;
		cmd.emit_stat = 1'b0;
		case (state_q)
			wwr_pkg::S_IDLE: cmd.op = wwr_pkg::DP_LOAD_IN;
			wwr_pkg::S_CHECK: begin
				if (!stat.started)
					cmd.op = wwr_pkg::DP_START;
				else if (stat.late)
					cmd.op = wwr_pkg::DP_MARK_LATE;
				else if (stat.full)
					cmd.op = wwr_pkg::DP_MARK_FULL;
				else
					cmd.op = wwr_pkg::DP_PUSH_INIT;
			end
			wwr_pkg::S_PUSH_RD:
				cmd.op = stat.i_zero ? wwr_pkg::DP_PUSH_ROOT : wwr_pkg::DP_PUSH_RD;
			wwr_pkg::S_PUSH_CMP:  cmd.op = wwr_pkg::DP_PUSH_CMP;
			wwr_pkg::S_FLUSH_CHK: cmd.op = wwr_pkg::DP_FLUSH_RD;
			wwr_pkg::S_FLUSH_TOP: cmd.op = wwr_pkg::DP_TOP;
			wwr_pkg::S_EMIT_REC: begin
				if (stat.rel_max)
					cmd.op = wwr_pkg::DP_DROP_CNT;
				else if (stat.out_free)
					cmd.op = wwr_pkg::DP_EMIT_REC;
			end
			wwr_pkg::S_POP_LAST: cmd.op = wwr_pkg::DP_POP_LAST;
			wwr_pkg::S_POP_LOAD: cmd.op = wwr_pkg::DP_POP_LOAD;
			wwr_pkg::S_POP_RD:   cmd.op = wwr_pkg::DP_POP_RD;
			wwr_pkg::S_POP_CMP:  cmd.pop_cmp = 1'b1;
			wwr_pkg::S_STATUS:   cmd.emit_stat = stat.out_free;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

>>> design/watermark_window_reorder.sv
// Watermark window reorder buffer: min-heap of records released window by window.
//
// Channels: rec_in takes one record (timestamp, record_tag) per transaction;
// rec_out gives the records released by that record, oldest first, then one
// status item with last set; cfg writes window (index 0) or watermark (index 1)
// and is always ready. Configure only while no record is in progress.
// A new record is taken only once the previous record's status item has been
// loaded into the output register; that item may still wait for the receiver.
// Per record: accept and check; unless the record is late or the heap is full,
// an insert that climbs the heap level by level; unless the record is late or
// the first, a window test before each released record and one that ends the
// flush, each release a pop that sifts down through the heap memory step by
// step; and last the status item.
// Heap memory has two registered read ports.
// A stalled receiver holds the output register and halts the sequencer at the next record or status item it would load.
// Reset empties the heap, clears the window and restores window 60 and
// watermark 10; heap memory contents need no clearing.
`default_nettype none
module watermark_window_reorder (
	input  wire       clk,
	input  wire       arst_n,
	wwr_in_if.sink    rec_in,
	wwr_out_if.source rec_out,
	wwr_cfg_if.sink   cfg
);
	wwr_pkg::dp_cmd_t  cmd;
	wwr_pkg::dp_stat_t stat;

	wwr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rec_in.valid),
		.stat     (stat),
		.cmd      (cmd)
	);

	wwr_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.rec_in  (rec_in),
		.rec_out (rec_out),
		.cfg     (cfg)
	);
endmodule
`default_nettype wire
